[hw/rtl/palette_fade_engine_unit_assert.svh]
// Assertion macros used by the checker
`ifndef PALETTE_FADE_ENGINE_UNIT_ASSERT_SVH
`define PALETTE_FADE_ENGINE_UNIT_ASSERT_SVH

// Implication in the same cycle
`define PFE_ASSERT_IMP(lbl, clk, rst_n, lhs, rhs) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("pfe assertion failed");

// Implication in the next cycle
`define PFE_ASSERT_NXT(lbl, clk, rst_n, lhs, rhs) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("pfe assertion failed");

`endif

[hw/rtl/pfe_pkg.sv]
`timescale 1ns / 1ps
package pfe_pkg;

    localparam int PFE_ENTRIES = 256;
    localparam int SIX_MAX     = 63;

    localparam logic [7:0] CFG_FIRST_INDEX = 8'd0;
    localparam logic [7:0] CFG_LAST_INDEX  = 8'd1;
    localparam logic [7:0] CFG_FADE_STEPS  = 8'd2;

    localparam logic [2:0] CMD_WRITE    = 3'd0;
    localparam logic [2:0] CMD_READ     = 3'd1;
    localparam logic [2:0] CMD_TARGET   = 3'd2;
    localparam logic [2:0] CMD_FADE_OUT = 3'd3;
    localparam logic [2:0] CMD_FADE_IN  = 3'd4;
    localparam logic [2:0] CMD_TICK     = 3'd5;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pfe_in_t;

    typedef struct packed {
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
        logic       fading;
        logic       faded;
        logic       finished;
    } pfe_out_t;

    // v*255/63 equals 4*v plus v/21 for v up to 63
    function automatic logic [7:0] scale_six(input logic [7:0] v);
        logic [5:0] c;
        logic [1:0] q;
        begin
            c = (v > 8'(SIX_MAX)) ? 6'(SIX_MAX) : v[5:0];
            if (c == 6'(SIX_MAX))
                q = 2'd3;
            else if (c >= 6'd42)
                q = 2'd2;
            else if (c >= 6'd21)
                q = 2'd1;
            else
                q = 2'd0;
            return {c, 2'b00} + 8'(q);
        end
    endfunction

endpackage

[hw/rtl/palette_fade_engine_unit.sv]
`timescale 1ns / 1ps
// Palette of PALETTE_ENTRIES colours with a fade sequencer. One transaction in gives one
// transaction out, and one transaction is handled at a time. After reset a clearing pass
// writes zero into every entry of the current and target palettes while the input stalls.
// Entry write, target write, unused commands and a tick while idle go straight to the
// output state; a read first waits for the palette RAM. Starting a fade copies the current
// palette to the snapshot entry by entry, with a read state and a write state per entry.
// A frame tick walks every entry: the final tick sets each entry to its goal, an entry
// outside the range takes its snapshot colour, and one inside it uses the shared
// interpolation unit: one multiply and an 8-step bit-serial divide for all three channels.
module palette_fade_engine_unit #(
    parameter int PALETTE_ENTRIES = pfe_pkg::PFE_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pfe_pkg::pfe_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output pfe_pkg::pfe_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import pfe_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_WAIT, S_COPY_RD, S_COPY_WR, S_TRD, S_EVAL, S_DIV, S_OUT
    } state_t;

    state_t               state_reg;
    logic [7:0]           first_reg, last_reg, steps_reg, frame_reg;
    logic                 active_reg, toward_reg, faded_reg, fin_reg, final_reg, ok_reg;
    color_t               solid_reg, rd_reg;
    logic [AW-1:0]        ptr_reg;
    pfe_out_t             out_reg;
    logic                 out_valid_reg;

    logic                 cur_we, cur_re, snap_we, snap_re, tgt_we;
    logic [AW-1:0]        cur_waddr, cur_raddr, tgt_waddr;
    color_t               cur_wdata, cur_rdata, snap_rdata, tgt_rdata, tgt_wdata, goal;
    color_t               div_result;
    logic                 accept, idx_ok, ptr_last, in_range, div_start, div_done, entry_done;
    logic [AW-1:0]        idx_addr;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign idx_ok    = {1'b0, in_data.index} < 9'(PALETTE_ENTRIES);
    assign idx_addr  = in_data.index[AW-1:0];
    assign ptr_last  = (ptr_reg == AW'(PALETTE_ENTRIES - 1));
    assign in_range  = (8'(ptr_reg) >= first_reg) && (8'(ptr_reg) <= last_reg);
    assign goal      = toward_reg ? tgt_rdata : solid_reg;
    assign div_start = (state_reg == S_EVAL) && !final_reg && in_range;
    assign entry_done = ((state_reg == S_EVAL) && !div_start)
                     || ((state_reg == S_DIV) && div_done);

    always_comb
    begin
        cur_we    = 1'b0;
        cur_waddr = ptr_reg;
        cur_wdata = snap_rdata;
        cur_re    = 1'b0;
        cur_raddr = ptr_reg;
        tgt_we    = 1'b0;
        tgt_waddr = idx_addr;
        tgt_wdata = color_t'({in_data.red, in_data.green, in_data.blue});
        snap_we   = (state_reg == S_COPY_WR);
        snap_re   = (state_reg == S_TRD);
        unique case (state_reg)
            S_CLEAR:
            begin
                cur_we    = 1'b1;
                cur_wdata = '0;
                tgt_we    = 1'b1;
                tgt_waddr = ptr_reg;
                tgt_wdata = '0;
            end
            S_IDLE:
            begin
                cur_raddr = idx_addr;
                cur_waddr = idx_addr;
                cur_wdata = color_t'({in_data.red, in_data.green, in_data.blue});
                if (accept && idx_ok)
                begin
                    cur_we = (in_data.cmd == CMD_WRITE);
                    cur_re = (in_data.cmd == CMD_READ);
                    tgt_we = (in_data.cmd == CMD_TARGET);
                end
            end
            S_COPY_RD:
            begin
                cur_re = 1'b1;
            end
            S_EVAL:
            begin
                cur_we    = !div_start;
                cur_wdata = final_reg ? goal : snap_rdata;
            end
            S_DIV:
            begin
                cur_we    = div_done;
                cur_wdata = div_result;
            end
            default:
            begin
                cur_we = 1'b0;
            end
        endcase
    end

    pfe_ram #(.DEPTH(PALETTE_ENTRIES), .WIDTH(24)) u_cur (
        .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
        .re(cur_re), .raddr(cur_raddr), .rdata(cur_rdata)
    );

    pfe_ram #(.DEPTH(PALETTE_ENTRIES), .WIDTH(24)) u_snap (
        .clk(clk), .we(snap_we), .waddr(ptr_reg),
        .wdata(cur_rdata),
        .re(snap_re), .raddr(ptr_reg), .rdata(snap_rdata)
    );

    pfe_ram #(.DEPTH(PALETTE_ENTRIES), .WIDTH(24)) u_tgt (
        .clk(clk), .we(tgt_we), .waddr(tgt_waddr),
        .wdata(tgt_wdata),
        .re(snap_re), .raddr(ptr_reg), .rdata(tgt_rdata)
    );

    pfe_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .snap(snap_rdata), .goal(goal),
        .step(frame_reg), .steps(steps_reg), .done(div_done), .result(div_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            first_reg     <= 8'd0;
            last_reg      <= 8'd255;
            steps_reg     <= 8'd30;
            frame_reg     <= '0;
            active_reg    <= 1'b0;
            toward_reg    <= 1'b0;
            faded_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            final_reg     <= 1'b0;
            ok_reg        <= 1'b0;
            solid_reg     <= '0;
            rd_reg        <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                priority if (cfg_index == CFG_FIRST_INDEX)
                    first_reg <= cfg_data;
                else if (cfg_index == CFG_LAST_INDEX)
                    last_reg <= cfg_data;
                else if (cfg_index == CFG_FADE_STEPS)
                    steps_reg <= cfg_data;
                else
                begin
                end
            end
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    ptr_reg   <= ptr_reg + AW'(1);
                    state_reg <= ptr_last ? S_IDLE : S_CLEAR;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        rd_reg  <= '0;
                        fin_reg <= 1'b0;
                        ok_reg  <= idx_ok;
                        ptr_reg <= '0;
                        unique case (in_data.cmd)
                            CMD_READ:
                                state_reg <= S_RD_WAIT;
                            CMD_FADE_OUT:
                            begin
                                solid_reg  <= color_t'({scale_six(in_data.red),
                                    scale_six(in_data.green), scale_six(in_data.blue)});
                                toward_reg <= 1'b0;
                                frame_reg  <= '0;
                                active_reg <= 1'b1;
                                state_reg  <= S_COPY_RD;
                            end
                            CMD_FADE_IN:
                            begin
                                toward_reg <= 1'b1;
                                frame_reg  <= '0;
                                active_reg <= 1'b1;
                                state_reg  <= S_COPY_RD;
                            end
                            CMD_TICK:
                            begin
                                final_reg <= !(frame_reg < steps_reg);
                                state_reg <= active_reg ? S_TRD : S_OUT;
                            end
                            default:
                                state_reg <= S_OUT;
                        endcase
                    end
                end
                S_RD_WAIT:
                begin
                    rd_reg    <= ok_reg ? cur_rdata : '0;
                    state_reg <= S_OUT;
                end
                S_COPY_RD:
                begin
                    state_reg <= S_COPY_WR;
                end
                S_COPY_WR:
                begin
                    ptr_reg   <= ptr_reg + AW'(1);
                    state_reg <= ptr_last ? S_OUT : S_COPY_RD;
                end
                S_TRD:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL, S_DIV:
                begin
                    if (div_start)
                    begin
                        state_reg <= S_DIV;
                    end
                    else if (entry_done)
                    begin
                        ptr_reg <= ptr_reg + AW'(1);
                        if (ptr_last)
                        begin
                            state_reg <= S_OUT;
                            if (final_reg)
                            begin
                                faded_reg  <= !toward_reg;
                                active_reg <= 1'b0;
                                fin_reg    <= 1'b1;
                            end
                            else
                            begin
                                frame_reg <= frame_reg + 8'd1;
                            end
                        end
                        else
                        begin
                            state_reg <= S_TRD;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg.read_red   <= rd_reg.red;
                        out_reg.read_green <= rd_reg.green;
                        out_reg.read_blue  <= rd_reg.blue;
                        out_reg.fading     <= active_reg;
                        out_reg.faded      <= faded_reg;
                        out_reg.finished   <= fin_reg;
                        out_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/pfe_ram.sv]
`timescale 1ns / 1ps
module pfe_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/pfe_div.sv]
`timescale 1ns / 1ps
module pfe_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  pfe_pkg::color_t snap,
    input  pfe_pkg::color_t goal,
    input  logic [7:0]     step,
    input  logic [7:0]     steps,
    output logic           done,
    output pfe_pkg::color_t result
);
    import pfe_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_MUL, D_DIV, D_FIN} dstate_t;

    dstate_t          state_reg;
    logic [2:0][7:0]  s_reg, absd_reg, rem_reg, shf_reg, quo_reg;
    logic [2:0]       neg_reg;
    logic [7:0]       step_reg, steps_reg;
    logic [2:0]       cnt_reg;
    logic             done_reg;
    logic [2:0][7:0]  s_in, g_in, res_next;
    logic [2:0][8:0]  d_in;
    logic [2:0][15:0] prod;
    logic [2:0][8:0]  rem2;

    assign s_in = snap;
    assign g_in = goal;
    assign done = done_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            d_in[c]     = {1'b0, g_in[c]} - {1'b0, s_in[c]};
            prod[c]     = 16'(absd_reg[c]) * 16'(step_reg);
            rem2[c]     = {rem_reg[c], shf_reg[c][7]};
            res_next[c] = neg_reg[c] ? (s_reg[c] - quo_reg[c]) : (s_reg[c] + quo_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            s_reg[c]    <= s_in[c];
                            neg_reg[c]  <= d_in[c][8];
                            absd_reg[c] <= d_in[c][8] ? 8'(-d_in[c]) : d_in[c][7:0];
                        end
                        step_reg  <= step;
                        steps_reg <= steps;
                        state_reg <= D_MUL;
                    end
                end
                D_MUL:
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        rem_reg[c] <= prod[c][15:8];
                        shf_reg[c] <= prod[c][7:0];
                        quo_reg[c] <= '0;
                    end
                    cnt_reg   <= '0;
                    state_reg <= D_DIV;
                end
                D_DIV:
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        shf_reg[c] <= {shf_reg[c][6:0], 1'b0};
                        if (rem2[c] >= {1'b0, steps_reg})
                        begin
                            rem_reg[c] <= 8'(rem2[c] - {1'b0, steps_reg});
                            quo_reg[c] <= {quo_reg[c][6:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg[c] <= rem2[c][7:0];
                            quo_reg[c] <= {quo_reg[c][6:0], 1'b0};
                        end
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN:
                begin
                    result    <= res_next;
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/pfe_checker.sv]
`timescale 1ns / 1ps
`include "palette_fade_engine_unit_assert.svh"
module pfe_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input pfe_pkg::pfe_in_t  in_data,
    input logic              out_valid,
    input logic              out_stall,
    input pfe_pkg::pfe_out_t out_data,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [7:0]        cfg_index,
    input logic [7:0]        cfg_data
);
    import pfe_pkg::*;

    `PFE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `PFE_ASSERT_IMP(a_fin_idle, clk, rst_n, out_valid && out_data.finished, !out_data.fading)
    `PFE_ASSERT_IMP(a_fin_nocol, clk, rst_n, out_valid && out_data.finished, ~|out_data.read_red)
    `PFE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

bind palette_fade_engine_unit pfe_checker u_pfe_checker (.*);
